// ===== src/endd_pkg.sv =====
// shared constants for the exit node decipher and deframer
`timescale 1ns / 1ps

package endd_pkg;

    // session key and cell geometry
    localparam int KEY_BYTES     = 32;
    localparam int PAYLOAD_BYTES = 256;
    localparam int HDR_BYTES     = 4;
    localparam int CELL_BYTES    = HDR_BYTES + PAYLOAD_BYTES;
    localparam int KEY_WORDS     = 4;

    // derived widths
    localparam int KPOS_W = 5;
    localparam int IDX_W  = $clog2(CELL_BYTES);
    localparam int LEN_W  = $clog2(PAYLOAD_BYTES + 1);
    localparam int CMP_W  = (IDX_W > LEN_W) ? IDX_W + 1 : LEN_W + 1;

    // configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_0   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_1   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_2   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_3   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CIPHER_ENABLE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_EXIT_MODE    = 3'd5;

    typedef logic [KEY_WORDS-1:0][APB_DATA_W-1:0] t_key;

endpackage

// ===== src/exit_node_decipher_deframer.sv =====
// exit node decipher and deframer top level
`timescale 1ns / 1ps
// an input transfer passes through the input register and then the result register to its result
// throughput: one byte per cycle; a new transfer is taken every cycle while results drain
// bytes that produce no result (length header, cell padding, after an error) leave nothing
// synchronous active-low reset clears the key, the mode bits, the key position, the cell
// state and the error latch; after a length error every byte is dropped until reset

module exit_node_decipher_deframer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // byte stream in
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_rx_byte,
    // results out
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [7:0]                       o_out_byte,
    output logic                             o_message_end,
    output logic                             o_length_error,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [endd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [endd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [endd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    // configuration registers
    endd_pkg::t_key r_key;
    logic           r_cipher_enable;
    logic           r_exit_mode;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // running state
    logic [endd_pkg::KPOS_W-1:0] r_key_pos;
    logic [endd_pkg::IDX_W-1:0]  r_idx;
    logic [endd_pkg::LEN_W-1:0]  r_len;
    logic                        r_len_high;   // length bits above the kept width were set
    logic                        r_error_stuck;

    // result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       r_out_err;

    // next values of the processing step
    logic [endd_pkg::KPOS_W-1:0] n_key_pos;
    logic [endd_pkg::IDX_W-1:0]  n_idx;
    logic [endd_pkg::LEN_W-1:0]  n_len;
    logic                        n_len_high;
    logic                        n_error_stuck;
    logic                        n_emit;
    logic [7:0]                  n_out_byte;
    logic                        n_out_end;
    logic                        n_out_err;

    logic                          advance;
    logic                          cfg_write;
    logic [endd_pkg::REG_IDX_W-1:0] cfg_idx;

    // scratch for the step
    logic [endd_pkg::KPOS_W-1:0] key_use;
    logic [endd_pkg::KPOS_W:0]   key_inc;
    logic [7:0]                  key_byte;
    logic [7:0]                  plain;
    logic [endd_pkg::IDX_W-1:0]  idx_use;
    logic [endd_pkg::IDX_W:0]    idx_inc;
    logic [endd_pkg::IDX_W-1:0]  pay_k;
    logic [31:0]                 len_acc;
    logic                        len_high_acc;

    // ------------------------------------------------------------------
    // configuration port: writes land on the access phase, reads are direct
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = paddr[endd_pkg::APB_ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key           <= '0;
            r_cipher_enable <= 1'b0;
            r_exit_mode     <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_idx)
                endd_pkg::REG_KEY_WORD_0:    r_key[0]        <= pwdata;
                endd_pkg::REG_KEY_WORD_1:    r_key[1]        <= pwdata;
                endd_pkg::REG_KEY_WORD_2:    r_key[2]        <= pwdata;
                endd_pkg::REG_KEY_WORD_3:    r_key[3]        <= pwdata;
                endd_pkg::REG_CIPHER_ENABLE: r_cipher_enable <= pwdata[0];
                endd_pkg::REG_EXIT_MODE:     r_exit_mode     <= pwdata[0];
                default: ;                   // unmapped addresses are ignored
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            endd_pkg::REG_KEY_WORD_0:    prdata = r_key[0];
            endd_pkg::REG_KEY_WORD_1:    prdata = r_key[1];
            endd_pkg::REG_KEY_WORD_2:    prdata = r_key[2];
            endd_pkg::REG_KEY_WORD_3:    prdata = r_key[3];
            endd_pkg::REG_CIPHER_ENABLE: prdata = {{(endd_pkg::APB_DATA_W-1){1'b0}},
                                                   r_cipher_enable};
            endd_pkg::REG_EXIT_MODE:     prdata = {{(endd_pkg::APB_DATA_W-1){1'b0}},
                                                   r_exit_mode};
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshakes: the held byte moves on whenever the result slot is free
    // or being emptied in the same cycle
    // ------------------------------------------------------------------
    assign advance = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // processing step for the held byte
    // ------------------------------------------------------------------
    always_comb begin
        // key stream: an out-of-range position restarts at the first key byte
        key_use  = ({1'b0, r_key_pos} >= (endd_pkg::KPOS_W+1)'(endd_pkg::KEY_BYTES))
                   ? '0 : r_key_pos;
        key_byte = r_key[key_use[4:3]][{key_use[2:0], 3'b000} +: 8];
        key_inc  = {1'b0, key_use} + 1'b1;
        plain    = r_cipher_enable ? (r_in_byte ^ key_byte) : r_in_byte;

        // cell position, wrapping after a full cell
        idx_use = ({1'b0, r_idx} >= (endd_pkg::IDX_W+1)'(endd_pkg::CELL_BYTES))
                  ? '0 : r_idx;
        idx_inc = {1'b0, idx_use} + 1'b1;
        pay_k   = idx_use - endd_pkg::IDX_W'(endd_pkg::HDR_BYTES);

        // little-endian length assembly, first header byte starts afresh
        len_acc = ((idx_use == '0) ? 32'd0 : 32'(r_len))
                  | (32'(plain) << {idx_use[1:0], 3'b000});
        len_high_acc = ((idx_use == '0) ? 1'b0 : r_len_high)
                       | (|len_acc[31:endd_pkg::LEN_W]);

        n_key_pos     = r_key_pos;
        n_idx         = r_idx;
        n_len         = r_len;
        n_len_high    = r_len_high;
        n_error_stuck = r_error_stuck;
        n_emit        = 1'b0;
        n_out_byte    = plain;
        n_out_end     = 1'b0;
        n_out_err     = 1'b0;

        if (!r_error_stuck) begin
            if (r_cipher_enable) begin
                n_key_pos = (key_inc >= (endd_pkg::KPOS_W+1)'(endd_pkg::KEY_BYTES))
                            ? '0 : key_inc[endd_pkg::KPOS_W-1:0];
            end

            if (!r_exit_mode) begin
                // relay: every byte goes out, cell state holds
                n_emit = 1'b1;
            end else if (idx_use < endd_pkg::IDX_W'(endd_pkg::HDR_BYTES)) begin
                // header byte of the cell
                n_len      = len_acc[endd_pkg::LEN_W-1:0];
                n_len_high = len_high_acc;
                n_idx      = idx_inc[endd_pkg::IDX_W-1:0];
                if (idx_use == endd_pkg::IDX_W'(endd_pkg::HDR_BYTES - 1) &&
                    (len_high_acc ||
                     len_acc[endd_pkg::LEN_W-1:0] >
                         endd_pkg::LEN_W'(endd_pkg::PAYLOAD_BYTES))) begin
                    // oversized length: one error result, then lock up
                    n_error_stuck = 1'b1;
                    n_emit        = 1'b1;
                    n_out_byte    = 8'd0;
                    n_out_err     = 1'b1;
                end
            end else begin
                // payload byte, kept only within the stated length
                if (endd_pkg::CMP_W'(pay_k) < endd_pkg::CMP_W'(r_len)) begin
                    n_emit    = 1'b1;
                    n_out_end = (endd_pkg::CMP_W'(pay_k) + 1'b1) == endd_pkg::CMP_W'(r_len);
                end
                n_idx = (idx_inc >= (endd_pkg::IDX_W+1)'(endd_pkg::CELL_BYTES))
                        ? '0 : idx_inc[endd_pkg::IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos     <= '0;
            r_idx         <= '0;
            r_len         <= '0;
            r_len_high    <= 1'b0;
            r_error_stuck <= 1'b0;
        end else if (advance) begin
            r_key_pos     <= n_key_pos;
            r_idx         <= n_idx;
            r_len         <= n_len;
            r_len_high    <= n_len_high;
            r_error_stuck <= n_error_stuck;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_emit;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_out_byte <= n_out_byte;
            r_out_end  <= n_out_end;
            r_out_err  <= n_out_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_message_end  = r_out_end;
    assign o_length_error = r_out_err;

endmodule
